FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL files of the task poller, included by the top file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define PTP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define PTP_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

FILE: rtl/core/ptp_pkg.sv
// Types and constants of the periodic task poller.
`default_nettype none
package ptp_pkg;

   localparam int NUM_TASKS = 8;
   localparam int TIME_BITS = 32;
   localparam int SLOT_W    = 3;
   localparam int FIELD_W   = 32;
   localparam int STEP_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int REQ_W     = 72;
   localparam int RSP_W     = 8;

   typedef enum logic [1:0] {
      CMD_POLL   = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_ACTIVE   = 2'd1,
      STAT_INACTIVE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POLL,
      ST_FLUSH
   } state_type;

   // payload of one task entry
   typedef struct packed {
      logic [SLOT_W-1:0]    slot;
      logic                 action_en;
      logic [TIME_BITS-1:0] period;
      logic [TIME_BITS-1:0] last_time;
   } task_type;

   typedef struct packed {
      logic     valid;
      task_type info;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                 clear;
      logic                 rotate;
      logic                 add;
      logic                 remove;
      logic [SLOT_W-1:0]    slot;
      logic                 action_en;
      logic [TIME_BITS-1:0] period;
   } cell_ctl_type;

endpackage
`default_nettype wire

FILE: rtl/core/ptp_cell.sv
// One list position of the task chain: holds one task and passes it to its neighbor.
`default_nettype none
module ptp_cell
   import ptp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   input  wire logic         prev_valid,
   input  wire logic         hit_in,
   input  wire entry_type    next_entry,
   output entry_type         entry,
   output logic              hit_out
);

   logic     valid_ff, valid_in;
   task_type data_ff, data_in;
   logic     own_hit, load, take;

   // match chain: a cell at or above the removed task shifts down
   assign own_hit = valid_ff && (data_ff.slot == ctl.slot);
   assign hit_out = hit_in | own_hit;

   // append lands on the first empty cell
   assign load = ctl.add && !valid_ff && prev_valid;
   assign take = ctl.rotate || (ctl.remove && hit_out);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (take) begin
         valid_in = next_entry.valid;
         data_in  = next_entry.info;
      end else if (load) begin
         valid_in          = 1'b1;
         data_in.slot      = ctl.slot;
         data_in.action_en = ctl.action_en;
         data_in.period    = ctl.period;
         data_in.last_time = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign entry.valid = valid_ff;
   assign entry.info  = data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/ptp_ctrl.sv
// Sequencer of the task poller: command decode, poll walk and result register.
`default_nettype none
module ptp_ctrl
   import ptp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [1:0]         req_cmd,
   input  wire logic [SLOT_W-1:0]  req_slot,
   input  wire logic [FIELD_W-1:0] req_period,
   input  wire logic               req_action_en,
   input  wire logic [FIELD_W-1:0] req_time,
   input  wire entry_type          head,
   input  wire logic               any_hit,
   input  wire logic               full,
   output cell_ctl_type            ctl,
   output entry_type               tail,
   output logic                    rsp_valid,
   input  wire logic               rsp_tready,
   output logic                    rsp_fired,
   output logic [SLOT_W-1:0]       rsp_task,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last
);

   state_type            state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]    pend_task_ff, pend_task_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_fired_ff, rsp_fired_in;
   logic [SLOT_W-1:0]    rsp_task_ff, rsp_task_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   cmd_type              cmd;
   logic                 out_free, accept, slot_ok, add_ok;
   status_type           add_status;
   logic [TIME_BITS-1:0] elapsed;
   logic                 fire, emit, advance, last_step;

   assign cmd      = cmd_type'(req_cmd);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept   = req_tvalid && req_tready;

   // add checks
   assign slot_ok = (32'(req_slot) < 32'(NUM_TASKS));
   assign add_ok  = slot_ok && !any_hit && !full;
   always_comb begin
      if (!slot_ok) begin
         add_status = STAT_INACTIVE;
      end else if (any_hit || full) begin
         add_status = STAT_ACTIVE;
      end else begin
         add_status = STAT_OK;
      end
   end

   // head cell check: wrapping elapsed time against the period
   assign elapsed   = now_ff - head.info.last_time;
   assign fire      = head.valid && (elapsed >= head.info.period);
   assign emit      = fire && head.info.action_en;
   assign advance   = !(emit && pend_valid_ff && !out_free);
   assign last_step = (step_ff == STEP_W'(NUM_TASKS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (cmd == CMD_POLL)) begin
               state_in = ST_POLL;
            end
         end
         ST_POLL: begin
            if (advance && last_step) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // cell commands, poll walk and result loading
   always_comb begin
      ctl           = '0;
      ctl.slot      = req_slot;
      ctl.action_en = req_action_en;
      ctl.period    = TIME_BITS'(req_period);
      tail          = '0;
      step_in       = step_ff;
      now_in        = now_ff;
      pend_valid_in = pend_valid_ff;
      pend_task_in  = pend_task_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_fired_in  = rsp_fired_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_fired_in  = 1'b0;
               rsp_task_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = STAT_OK;
               unique case (cmd)
                  CMD_POLL: begin
                     now_in        = TIME_BITS'(req_time);
                     step_in       = '0;
                     pend_valid_in = 1'b0;
                  end
                  CMD_ADD: begin
                     ctl.add       = add_ok;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = add_status;
                  end
                  CMD_REMOVE: begin
                     ctl.remove    = any_hit;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = any_hit ? STAT_OK : STAT_INACTIVE;
                  end
                  CMD_CLEAR: begin
                     ctl.clear    = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         ST_POLL: begin
            if (advance) begin
               ctl.rotate = 1'b1;
               tail       = head;
               if (fire) begin
                  tail.info.last_time = now_ff;
               end
               step_in = step_ff + 1'b1;
               if (emit) begin
                  // earlier firing is now known not to be the last one
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_fired_in  = 1'b1;
                     rsp_task_in   = pend_task_ff;
                     rsp_status_in = STAT_OK;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_task_in  = head.info.slot;
               end
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_fired_in  = 1'b1;
               rsp_task_in   = pend_task_ff;
               rsp_status_in = STAT_OK;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
            pend_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      now_ff        <= now_in;
      pend_task_ff  <= pend_task_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_fired  = rsp_fired_ff;
   assign rsp_task   = rsp_task_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
`default_nettype wire

FILE: rtl/core/periodic_task_poller.sv
// Add, remove, clear: one item accepted per cycle when idle and the output is free; result
// valid the next cycle. Poll: after the accept the chain rotates one cell per cycle past the
// head check through all NUM_TASKS cells, then the flush state; the input is held until idle
// again; output stalls stretch the walk.
// A poll that fires nothing gives no result; a fired task waits for the next one or the flush.
// Synchronous reset empties the task table and drops any result in flight.
`default_nettype none
`include "assert_macros.svh"
module periodic_task_poller
   import ptp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // [2:0] task_slot, [34:3] period_ticks, [35] action_enable, [67:36] current_time
   input  wire logic [REQ_W-1:0] req_tdata,
   // [1:0] cmd
   input  wire logic [1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // [0] fired_valid, [3:1] fired_task, [5:4] status
   output logic [RSP_W-1:0]      rsp_tdata,
   // last_of_run
   output logic                  rsp_tlast
);

   cell_ctl_type         ctl;
   entry_type            tail;
   entry_type            entries [NUM_TASKS];
   logic [NUM_TASKS-1:0] hit;
   logic [NUM_TASKS-1:0] cell_valid;
   logic                 rsp_fired;
   logic [SLOT_W-1:0]    rsp_task;
   logic [1:0]           rsp_status;
   logic                 chain_gap;
   logic                 table_acc;

   ptp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_cmd       (req_tuser),
      .req_slot      (req_tdata[2:0]),
      .req_period    (req_tdata[34:3]),
      .req_action_en (req_tdata[35]),
      .req_time      (req_tdata[67:36]),
      .head          (entries[0]),
      .any_hit       (hit[NUM_TASKS-1]),
      .full          (cell_valid[NUM_TASKS-1]),
      .ctl           (ctl),
      .tail          (tail),
      .rsp_valid     (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_fired     (rsp_fired),
      .rsp_task      (rsp_task),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_tlast)
   );

   // chain of cells in list order; the tail cell takes the updated head on a rotate
   for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
      entry_type next_entry;
      logic      prev_valid;
      logic      hit_in;

      if (i == NUM_TASKS - 1) begin : g_tail
         assign next_entry = tail;
      end else begin : g_mid
         assign next_entry = entries[i+1];
      end

      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
         assign hit_in     = 1'b0;
      end else begin : g_rest
         assign prev_valid = cell_valid[i-1];
         assign hit_in     = hit[i-1];
      end

      ptp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_valid (prev_valid),
         .hit_in     (hit_in),
         .next_entry (next_entry),
         .entry      (entries[i]),
         .hit_out    (hit[i])
      );

      assign cell_valid[i] = entries[i].valid;
   end

   assign rsp_tdata = {2'b00, rsp_status, rsp_task, rsp_fired};

   // helpers for the checks below
   assign chain_gap = (((cell_valid + NUM_TASKS'(1)) & cell_valid) != '0);
   assign table_acc = req_tvalid && req_tready && (req_tuser != CMD_POLL);

   // while idle, occupied cells form one run from the head (a poll rotates them)
   `PTP_NEVER(a_valid_prefix, req_tready && chain_gap, "task chain has a gap")

   // every table command gets its status result in the next cycle
   `PTP_ASSERT(a_cmd_result, table_acc |=> rsp_tvalid, "table command result missing")

   // only fired tasks can be followed by more results of the same item
   `PTP_NEVER(a_status_last, rsp_tvalid && !rsp_fired && !rsp_tlast, "status not last")

   // fired results always carry an ok status
   `PTP_NEVER(a_fired_ok, rsp_tvalid && rsp_fired && (rsp_status != STAT_OK), "fired not ok")

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the periodic task poller: directed and random stream traffic.
`timescale 1ns / 1ps
module tb_top
   import ptp_pkg::*;
();

   localparam int HALF_PERIOD = 6;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES = 200;
   localparam int TAIL_CYCLES = 40;
   localparam int RANDOM_ITEMS = 126;

   // one result item as the block should deliver it
   typedef struct {
      logic       fired;
      logic [2:0] slot_id;
      status_type status;
      logic       last;
   } firing_type;

   // Task table mirror plus the queue of results still owed by the block
   class poller_scoreboard;
      bit          active [NUM_TASKS];
      logic [31:0] period [NUM_TASKS];
      logic [31:0] last_fire [NUM_TASKS];
      bit          report_en [NUM_TASKS];
      logic [2:0]  visit_order [NUM_TASKS];
      int          task_cnt;
      firing_type  due_results[$];
      int          errors;

      function new();
         foreach (active[i]) active[i] = 0;
         task_cnt = 0;
         errors = 0;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      // apply one accepted item to the table and queue the results it causes
      function void note_request(cmd_type cmd, logic [2:0] slot, logic [31:0] per,
                                 logic en, logic [31:0] now);
         firing_type r;
         logic [2:0] fired_list [$];
         logic [2:0] t;
         logic [31:0] elapsed;
         int         pos;
         r.fired = 1'b0;
         r.slot_id = 3'd0;
         r.status = STAT_OK;
         r.last = 1'b1;
         case (cmd)
            CMD_ADD: begin
               if (active[slot] || task_cnt >= NUM_TASKS) begin
                  r.status = STAT_ACTIVE;
               end else begin
                  active[slot] = 1;
                  period[slot] = per;
                  last_fire[slot] = '0;
                  report_en[slot] = en;
                  visit_order[task_cnt] = slot;
                  task_cnt++;
               end
               due_results.push_back(r);
            end
            CMD_REMOVE: begin
               if (!active[slot]) begin
                  r.status = STAT_INACTIVE;
               end else begin
                  active[slot] = 0;
                  pos = -1;
                  for (int i = 0; i < task_cnt; i++)
                     if (pos < 0 && visit_order[i] == slot) pos = i;
                  if (pos >= 0) begin
                     for (int j = pos; j + 1 < task_cnt; j++)
                        visit_order[j] = visit_order[j + 1];
                     task_cnt--;
                  end
               end
               due_results.push_back(r);
            end
            CMD_CLEAR: begin
               foreach (active[i]) active[i] = 0;
               task_cnt = 0;
               due_results.push_back(r);
            end
            default: begin
               // poll: walk the list, expired tasks restart at now
               for (int i = 0; i < task_cnt; i++) begin
                  t = visit_order[i];
                  elapsed = now - last_fire[t];
                  if (active[t] && elapsed >= period[t]) begin
                     last_fire[t] = now;
                     if (report_en[t]) fired_list.push_back(t);
                  end
               end
               foreach (fired_list[k]) begin
                  r.fired = 1'b1;
                  r.slot_id = fired_list[k];
                  r.status = STAT_OK;
                  r.last = (k == fired_list.size() - 1);
                  due_results.push_back(r);
               end
            end
         endcase
      endfunction

      function void compare(string field, logic [3:0] want, logic [3:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      // match one accepted result against the oldest owed one
      function void check_response(logic [RSP_W-1:0] data, logic last);
         firing_type want;
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual data %h last %b",
                     $time, data, last);
            errors++;
            return;
         end
         want = due_results.pop_front();
         compare("fired_valid", want.fired, data[0]);
         compare("fired_task", want.slot_id, data[3:1]);
         compare("status", want.status, data[5:4]);
         compare("last_of_run", want.last, last);
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata;   // [2:0] task_slot, [34:3] period_ticks,
                                      // [35] action_enable, [67:36] current_time
   logic [1:0]           req_tuser;   // [1:0] cmd
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;   // [0] fired_valid, [3:1] fired_task, [5:4] status
   logic                 rsp_tlast;   // last_of_run

   poller_scoreboard sb;
   bit               no_idle;
   bit               hold_req;
   int               idle_cycles;
   logic [31:0]      tick;

   periodic_task_poller DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #HALF_PERIOD clock = ~clock;

   // Watchdog: too long without any item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("FAIL periodic_task_poller");
            $finish;
         end
      end
   end

   // Result sink: random stalls, one long hold-off on request
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 0;
         end
         stall = no_idle ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tdata, rsp_tlast);
      end
   end

   // Offer one item after a random gap; returns at the falling edge after acceptance
   task automatic send_item(cmd_type cmd, logic [2:0] slot, logic [31:0] per,
                            logic en, logic [31:0] now);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, now, en, per, slot};
      req_tuser <= cmd;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, slot, per, en, now);
      @(negedge clock);
   endtask

   // Stop offering until every owed result has come back
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // One random item, mostly well-formed table traffic and polls with advancing time
   task automatic send_random();
      int         roll;
      int         add_lim;
      cmd_type    cmd;
      logic [31:0] per;
      logic [31:0] now;
      roll = $urandom_range(0, 99);
      add_lim = (sb.task_cnt < 4) ? 34 : 14;
      per = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 60);
      now = $urandom();
      if (roll < 4) begin
         cmd = CMD_CLEAR;
      end else if (roll < add_lim) begin
         cmd = CMD_ADD;
      end else if (roll < add_lim + 12) begin
         cmd = CMD_REMOVE;
      end else begin
         cmd = CMD_POLL;
         if ($urandom_range(0, 9) == 0) tick = $urandom();
         else tick = tick + $urandom_range(0, 40);
         now = tick;
      end
      send_item(cmd, 3'($urandom_range(0, 7)), per, $urandom_range(0, 3) != 0, now);
   endtask

   // Stimulus
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_POLL;
      no_idle = 0;
      hold_req = 0;
      idle_cycles = 0;
      tick = '0;
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, status codes, period and time extremes, wrap
      send_item(CMD_POLL, 3'd0, 32'd0, 1'b0, 32'd0);             // poll with nothing to fire
      send_item(CMD_CLEAR, 3'd0, 32'd0, 1'b0, 32'd0);            // clear of an empty table
      send_item(CMD_REMOVE, 3'd3, 32'd0, 1'b0, 32'd0);           // remove of an inactive slot
      send_item(CMD_ADD, 3'd0, 32'd0, 1'b1, 32'hFFFF_FFFF);      // zero period
      send_item(CMD_ADD, 3'd0, 32'd5, 1'b1, 32'd0);              // add to an active slot
      send_item(CMD_ADD, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'd0);      // largest period
      send_item(CMD_ADD, 3'd5, 32'd10, 1'b0, 32'd0);             // action disabled
      send_item(CMD_ADD, 3'd2, 32'd100, 1'b1, 32'd0);
      send_item(CMD_POLL, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'd5);
      send_item(CMD_POLL, 3'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);     // all expire
      send_item(CMD_POLL, 3'd0, 32'd0, 1'b0, 32'd3);             // time wraps past zero
      send_item(CMD_REMOVE, 3'd0, 32'd0, 1'b0, 32'd0);
      send_item(CMD_REMOVE, 3'd0, 32'd0, 1'b0, 32'd0);
      send_item(CMD_ADD, 3'd0, 32'd1, 1'b1, 32'd0);              // re-added at the tail
      send_item(CMD_ADD, 3'd1, 32'd2, 1'b1, 32'd0);
      send_item(CMD_ADD, 3'd3, 32'd3, 1'b1, 32'd0);
      send_item(CMD_ADD, 3'd4, 32'h8000_0000, 1'b1, 32'd0);
      send_item(CMD_ADD, 3'd6, 32'd0, 1'b1, 32'd0);              // table now full
      send_item(CMD_ADD, 3'd6, 32'd9, 1'b0, 32'd0);
      send_item(CMD_POLL, 3'd0, 32'd0, 1'b0, 32'h8000_0000);
      send_item(CMD_POLL, 3'd0, 32'd0, 1'b0, 32'h8000_0001);
      send_item(CMD_CLEAR, 3'd0, 32'd0, 1'b0, 32'd0);
      send_item(CMD_POLL, 3'd0, 32'd0, 1'b0, 32'd1);
      send_item(CMD_CLEAR, 3'd0, 32'd0, 1'b0, 32'd0);

      // random traffic with a back-pressure phase and an idle-free stretch
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 50) begin
            wait_drain();
            send_item(CMD_CLEAR, 3'd0, 32'd0, 1'b0, 32'd0);
            for (int s = 0; s < NUM_TASKS; s++)
               send_item(CMD_ADD, s[2:0], 32'd0, 1'b1, $urandom());
            hold_req = 1;
            for (int p = 0; p < 6; p++) begin
               tick = tick + 1;
               send_item(CMD_POLL, 3'($urandom_range(0, 7)), $urandom(), 1'b0, tick);
            end
            n += 15;
         end
         no_idle = (n >= 90 && n < 120);
         send_random();
      end
      no_idle = 0;

      // drain, then allow the block to settle
      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS periodic_task_poller");
      end else begin
         $display("FAIL periodic_task_poller");
      end
      $finish;
   end

endmodule

FILE: periodic_task_poller.f
+incdir+rtl/core
rtl/core/ptp_pkg.sv
rtl/core/ptp_cell.sv
rtl/core/ptp_ctrl.sv
rtl/core/periodic_task_poller.sv
sim/tb_top.sv
